// ===== src/mtf_pkg.sv =====
`timescale 1ns / 1ps
package mtf_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OccW  = $clog2(Depth + 1);
  localparam int unsigned ValW  = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned PosW  = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_MTF    = 2'd2
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic insert_en;
    logic move_en;
    logic result_en;
  } ctrl_t;

  typedef struct packed {
    logic is_insert;
    logic is_move;
    logic full;
    logic hit;
  } stat_t;

endpackage

// ===== src/mtf_if.sv =====
`timescale 1ns / 1ps
interface mtf_req_if;
  import mtf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic signed [ValW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface mtf_rsp_if;
  import mtf_pkg::*;
  logic            valid;
  logic            ready;
  logic [StW-1:0]  status;
  logic [PosW-1:0] position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

// ===== src/mtf_datapath.sv =====
`timescale 1ns / 1ps
module mtf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtf_pkg::ctrl_t                 ctrl_i,
  output mtf_pkg::stat_t                 stat_o,
  input  logic [mtf_pkg::CmdW-1:0]       command_i,
  input  logic signed [mtf_pkg::ValW-1:0] value_i,
  output logic [mtf_pkg::StW-1:0]        status_o,
  output logic [mtf_pkg::PosW-1:0]       position_o
);
  import mtf_pkg::*;

  logic [ValW-1:0] entries_q [Depth];
  logic [OccW-1:0] occ_q, occ_d;
  logic [CmdW-1:0] cmd_q;
  logic [ValW-1:0] value_q;
  logic [Depth-1:0] match_q, match_d;
  logic [StW-1:0]  status_q, status_d;
  logic [PosW-1:0] position_q, position_d;
  logic [IdxW-1:0] hit_idx;
  logic            hit;
  logic            full;
  logic [Depth-1:0] shift_mask;

  // slot-wise compare against live entries only
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match_d[i] = (entries_q[i] == value_q) && (OccW'(i) < occ_q);
    end
  end

  // first match nearest the front
  always_comb begin
    hit_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  assign hit  = |match_q;
  assign full = (occ_q == OccW'(Depth));

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      shift_mask[i] = ctrl_i.insert_en || (ctrl_i.move_en && (IdxW'(i) <= hit_idx));
    end
  end

  always_comb begin
    status_d   = ST_MISS;
    position_d = '0;
    case (cmd_q)
      CMD_INSERT: begin
        status_d = full ? ST_FULL : ST_OK;
      end
      CMD_SEARCH, CMD_MTF: begin
        if (hit) begin
          status_d   = ST_OK;
          position_d = PosW'(hit_idx);
        end
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  assign occ_d = ctrl_i.insert_en ? occ_q + OccW'(1) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= command_i;
      value_q <= value_i;
    end
    if (ctrl_i.compare) begin
      match_q <= match_d;
    end
    if (ctrl_i.result_en) begin
      status_q   <= status_d;
      position_q <= position_d;
    end
    for (int i = 0; i < Depth; i++) begin
      if (shift_mask[i]) begin
        entries_q[i] <= (i == 0) ? value_q : entries_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign stat_o.is_insert = (cmd_q == CMD_INSERT);
  assign stat_o.is_move   = (cmd_q == CMD_MTF);
  assign stat_o.full      = full;
  assign stat_o.hit       = hit;
  assign status_o         = status_q;
  assign position_o       = position_q;

endmodule

// ===== src/mtf_ctrl.sv =====
`timescale 1ns / 1ps
module mtf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output mtf_pkg::ctrl_t ctrl_o,
  input  mtf_pkg::stat_t stat_i
);
  import mtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   req_fire;
  logic   rsp_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_free    = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    ctrl_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          ctrl_o.load = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        ctrl_o.compare = 1'b1;
        state_d        = S_UPD;
      end
      S_UPD: begin
        if (rsp_free) begin
          ctrl_o.insert_en = stat_i.is_insert && !stat_i.full;
          ctrl_o.move_en   = stat_i.is_move && stat_i.hit;
          ctrl_o.result_en = 1'b1;
          rsp_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_accept_to_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_CMP)
    else $error("accepted request did not enter compare");

  a_result_from_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.result_en |=> rsp_valid_q && state_q == S_IDLE)
    else $error("result loaded without valid response");

  a_insert_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.insert_en |-> stat_i.is_insert && !stat_i.full && state_q == S_UPD)
    else $error("insert on full list");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_ready_i |-> !ctrl_o.result_en)
    else $error("pending response overwritten");

endmodule

// ===== src/move_to_front_list.sv =====
`timescale 1ns / 1ps
// an accepted request passes the compare state, then the update state, before its
//   response is valid; a new request is taken only in idle, after that pass over
//   the slot register row; a stalled response holds the update step
// reset: asynchronous active low; clears occupancy and handshake state,
//   list slots are not cleared
module move_to_front_list (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtf_req_if.sink   req_i,
  mtf_rsp_if.source rsp_o
);
  import mtf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  mtf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .command_i  (req_i.command),
    .value_i    (req_i.value),
    .status_o   (rsp_o.status),
    .position_o (rsp_o.position)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import mtf_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int RandomItems = 1450;
  localparam int DrainEvery  = 480;
  localparam int SettleCycles = 20;
  localparam int CycleLimit  = 600000;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [ValW-1:0] value;
    logic            drain;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtf_req_if req_if ();
  mtf_rsp_if rsp_if ();

  move_to_front_list uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the list, front at index 0
  logic [ValW-1:0] list_mem [Depth];
  int              list_occ = 0;

  req_t req_pending_q [$];
  rsp_t rsp_due_q [$];

  // generator-side view of the held values, order ignored
  logic [ValW-1:0] held_pool [$];
  int              gen_occ = 0;

  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;
  int   send_gap = 0;
  int   rsp_stall = 0;
  int   cycles = 0;
  int   err_count = 0;

  int          n_rsp = 0;
  int          n_insert = 0;
  int          n_full = 0;
  int          n_hit = 0;
  int          n_miss = 0;
  int          n_unused = 0;
  int          n_moved = 0;
  logic [15:0] pos_seen = '0;

  task automatic list_update(input logic [CmdW-1:0] cmd, input logic [ValW-1:0] val,
                             output rsp_t res);
    int hit;
    hit = -1;
    res.status = ST_MISS;
    res.position = '0;
    if (cmd == CMD_INSERT) begin
      if (list_occ >= Depth) begin
        res.status = ST_FULL;
      end else begin
        for (int i = list_occ; i > 0; i--) list_mem[i] = list_mem[i-1];
        list_mem[0] = val;
        list_occ++;
        res.status = ST_OK;
      end
    end else if (cmd == CMD_SEARCH || cmd == CMD_MTF) begin
      for (int i = 0; i < list_occ; i++) begin
        if (hit < 0 && list_mem[i] == val) hit = i;
      end
      if (hit >= 0) begin
        res.status = ST_OK;
        res.position = hit[PosW-1:0];
        if (cmd == CMD_MTF) begin
          for (int i = hit; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = val;
        end
      end
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycles / 600) % 4 == 3) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic add_req(input logic [CmdW-1:0] cmd, input logic [ValW-1:0] val,
                         input logic drain);
    req_t item;
    item.command = cmd;
    item.value = val;
    item.drain = drain;
    req_pending_q.push_back(item);
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // request driver
  always @(negedge clk) begin
    req_t nxt;
    if (rst_n) begin
      if (!(req_if.valid && !req_taken)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (req_pending_q.size() != 0 &&
                     !(req_pending_q[0].drain && rsp_due_q.size() != 0)) begin
          nxt = req_pending_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.command <= nxt.command;
          req_if.value <= nxt.value;
          send_gap <= draw_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready with random stalls
  always @(negedge clk) begin
    int s;
    if (rst_n) begin
      s = rsp_stall;
      if (rsp_taken) s = draw_gap();
      else if (s == 0 && $urandom_range(0, 9) == 0) s = draw_gap();
      if (s > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall <= s - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_stall <= 0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    rsp_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, rsp_due_q.size());
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n) begin
      req_taken <= req_if.valid && req_if.ready;
      rsp_taken <= rsp_if.valid && rsp_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        n_rsp++;
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response status %0d position %0d",
                                    rsp_if.status, rsp_if.position));
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_if.status !== want.status || rsp_if.position !== want.position)
            report_mismatch($sformatf("status exp %0d got %0d, position exp %0d got %0d",
                                      want.status, rsp_if.status, want.position,
                                      rsp_if.position));
        end
      end
      if (req_if.valid && req_if.ready) begin
        list_update(req_if.command, req_if.value, want);
        rsp_due_q.push_back(want);
        if (req_if.command == CMD_INSERT) begin
          n_insert++;
          if (want.status == ST_FULL) n_full++;
        end else if (req_if.command == CMD_UNUSED) begin
          n_unused++;
        end else if (want.status == ST_OK) begin
          n_hit++;
          pos_seen[want.position] = 1'b1;
          if (req_if.command == CMD_MTF && want.position != 0) n_moved++;
        end else begin
          n_miss++;
        end
      end
    end
  end

  initial begin
    int counted;
    int r;
    logic [CmdW-1:0] cmd;
    logic [ValW-1:0] val;
    counted = 0;
    req_if.valid = 1'b0;
    req_if.command = CMD_INSERT;
    req_if.value = '0;
    rsp_if.ready = 1'b0;

    // empty list, extremes, duplicates, moves from front and from deep
    add_req(CMD_SEARCH, 32'h0000_0005, 1'b0);
    add_req(CMD_MTF, 32'h0000_0005, 1'b0);
    add_req(CMD_UNUSED, 32'h0000_0000, 1'b0);
    add_req(CMD_INSERT, 32'h8000_0000, 1'b0);
    add_req(CMD_INSERT, 32'h7fff_ffff, 1'b0);
    add_req(CMD_INSERT, 32'h0000_0000, 1'b0);
    add_req(CMD_INSERT, 32'hffff_ffff, 1'b0);
    add_req(CMD_INSERT, 32'h7fff_ffff, 1'b0);
    add_req(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    add_req(CMD_SEARCH, 32'h8000_0000, 1'b0);
    add_req(CMD_MTF, 32'h7fff_ffff, 1'b0);
    add_req(CMD_MTF, 32'h8000_0000, 1'b0);
    add_req(CMD_SEARCH, 32'h1234_5678, 1'b0);
    add_req(CMD_MTF, 32'h0000_0001, 1'b0);
    add_req(CMD_UNUSED, 32'h8000_0000, 1'b0);
    add_req(CMD_SEARCH, 32'h0000_0000, 1'b0);
    add_req(CMD_MTF, 32'hffff_ffff, 1'b0);
    add_req(CMD_INSERT, 32'ha5a5_a5a5, 1'b0);
    add_req(CMD_INSERT, 32'h5a5a_5a5a, 1'b0);
    add_req(CMD_SEARCH, 32'h8000_0000, 1'b0);
    add_req(CMD_MTF, 32'h7fff_ffff, 1'b0);
    held_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h7fff_ffff, 32'ha5a5_a5a5, 32'h5a5a_5a5a};
    gen_occ = held_pool.size();

    // random traffic, mostly lookups of held values; the list fills up early
    while (counted < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        add_req(CMD_UNUSED, $urandom, 1'b0);
      end else begin
        if (r < 14) begin
          cmd = CMD_INSERT;
          case ($urandom_range(0, 6))
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2, 3: val = held_pool[$urandom_range(0, held_pool.size() - 1)];
            default: val = $urandom;
          endcase
          if (gen_occ < Depth) begin
            held_pool.push_back(val);
            gen_occ++;
          end
        end else begin
          cmd = (r < 54) ? CMD_MTF : CMD_SEARCH;
          val = held_pool[$urandom_range(0, held_pool.size() - 1)];
          case ($urandom_range(0, 9))
            0: val = $urandom;
            1: val = val ^ (32'h1 << $urandom_range(0, ValW - 1));
            default: ;
          endcase
        end
        add_req(cmd, val, counted % DrainEvery == DrainEvery - 1);
        counted++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_pending_q.size() != 0 || req_if.valid) @(negedge clk);
    while (rsp_due_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("%0d responses checked: %0d inserts (%0d refused on a full list), %0d hits, %0d misses",
             n_rsp, n_insert, n_full, n_hit, n_miss);
    $display("%0d unused commands, %0d deep moves to front, hit positions seen %b",
             n_unused, n_moved, pos_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== move_to_front_list.f =====
src/mtf_pkg.sv
src/mtf_if.sv
src/mtf_datapath.sv
src/mtf_ctrl.sv
src/move_to_front_list.sv
verif/tb.sv
